// ----- src/dirty_row_span_merger_unit_defines.svh -----
// Assertion macros for the dirty row span merger checker.
// No dependencies; included by the checker file.
`ifndef DIRTY_ROW_SPAN_MERGER_UNIT_DEFINES_SVH
`define DIRTY_ROW_SPAN_MERGER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DRSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DRSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/drsm_pkg.sv -----
// Shared constants, opcodes and control/status structs for the span merger.
// No dependencies; used by every module of the block.
package drsm_pkg;

    localparam int SPAN_SLOTS = 6;
    localparam int CNT_W      = $clog2(SPAN_SLOTS + 1);
    localparam int IDX_W      = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
    localparam int ROW_W      = 12;
    localparam int IN_ROW_W   = 13;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = ((2 * IN_ROW_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * ROW_W + CNT_W + 7) / 8) * 8;

    localparam logic [ROW_W-1:0] SCREEN_ROWS_RESET = ROW_W'(480);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LIST  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // latch clamped range of accepted request
        logic clear_set;   // drop all stored spans
        logic idx_clear;
        logic idx_inc;
        logic absorb;      // merge slot[idx] into working range
        logic take_best;   // merge nearest slot into working range
        logic move_last;   // last slot fills the freed slot
        logic gap_start;
        logic gap_step;
        logic store_new;   // append working range
        logic emit_flag;   // result without span
        logic emit_span;   // result carrying slot[idx]
    } drsm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  in_op;
        logic in_empty;    // clamped range of the input is empty
        logic count_zero;
        logic scan_end;    // idx reached count
        logic full;
        logic hit;         // slot[idx] overlaps or touches working range
        logic gap_last;
        logic list_last;
        logic out_free;
    } drsm_sts_t;

endpackage

// ----- src/dirty_row_span_merger_unit.sv -----
// Sequence from the accepting edge through the one loading the output register: clear,
// unused op, dropped add or empty list go straight to the result; list emits one result
// per stored span; add scans the slots, each absorbed span costs a slot move and restarts
// the scan at slot 0; a full set adds a nearest-gap search over all slots before that merge.
// Throughput: one request at a time; s_tready returns once the final result is registered.
// Reset (aresetn low, synchronous): span count 0, screen_rows 480, output empty; slots kept.
module dirty_row_span_merger_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: screen_rows
    input  logic                           cfg_we,
    input  logic [drsm_pkg::ROW_W-1:0]     cfg_wdata,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [drsm_pkg::S_TDATA_W-1:0] s_tdata,  // start row[12:0], end_row[25:13], zeros
    input  logic [drsm_pkg::OP_W-1:0]      s_tuser,  // operation[1:0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drsm_pkg::M_TDATA_W-1:0] m_tdata,  // span_start, span_end, span_count, zeros
    output logic                           m_tuser,  // span_valid
    output logic                           m_tlast
);
    import drsm_pkg::*;

    drsm_cmd_t cmd;
    drsm_sts_t sts;

    // Controller: one-hot sequencer walking scan / absorb / gap search / list.
    drsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: slot registers, working range, clamp, gap compare,
    // output register that decouples the result stream from the sequencer.
    drsm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- src/drsm_ctrl.sv -----
// Sequencer for add / clear / list requests of the span merger.
// Depends on drsm_pkg; drives drsm_dp through drsm_cmd_t.
module drsm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  drsm_pkg::drsm_sts_t  sts,
    output drsm_pkg::drsm_cmd_t  cmd
);
    import drsm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_MOVE  = 8'b0000_0100,
        ST_GAP   = 8'b0000_1000,
        ST_BEST  = 8'b0001_0000,
        ST_STORE = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_LIST  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    case (sts.in_op)
                        OP_ADD: begin
                            cmd.idx_clear = 1'b1;
                            state_next    = sts.in_empty ? ST_DONE : ST_SCAN;
                        end
                        OP_CLEAR: begin
                            cmd.clear_set = 1'b1;
                            state_next    = ST_DONE;
                        end
                        OP_LIST: begin
                            cmd.idx_clear = 1'b1;
                            state_next    = sts.count_zero ? ST_DONE : ST_LIST;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (sts.scan_end) begin
                    if (sts.full) begin
                        cmd.gap_start = 1'b1;
                        state_next    = ST_GAP;
                    end else begin
                        state_next = ST_STORE;
                    end
                end else if (sts.hit) begin
                    cmd.absorb = 1'b1;
                    state_next = ST_MOVE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_MOVE: begin
                cmd.move_last = 1'b1;
                cmd.idx_clear = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_GAP: begin
                cmd.gap_step = 1'b1;
                if (sts.gap_last) begin
                    state_next = ST_BEST;
                end
            end
            ST_BEST: begin
                cmd.take_best = 1'b1;
                state_next    = ST_MOVE;
            end
            ST_STORE: begin
                cmd.store_new = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit_flag = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (sts.out_free) begin
                    cmd.emit_span = 1'b1;
                    if (sts.list_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/drsm_dp.sv -----
// Datapath: span slots, working range, gap search and output register.
// Depends on drsm_pkg; commanded by drsm_ctrl.
module drsm_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [drsm_pkg::ROW_W-1:0]     cfg_wdata,
    input  logic [drsm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [drsm_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [drsm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  drsm_pkg::drsm_cmd_t            cmd,
    output drsm_pkg::drsm_sts_t            sts
);
    import drsm_pkg::*;

    localparam int PAD_W = M_TDATA_W - 2 * ROW_W - CNT_W;

    logic [ROW_W-1:0] screen_rows_reg;
    logic [ROW_W-1:0] starts_reg [SPAN_SLOTS];
    logic [ROW_W-1:0] ends_reg   [SPAN_SLOTS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [ROW_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic signed [ROW_W:0] min_gap_reg, min_gap_next;

    logic                  m_valid_reg;
    logic                  m_span_reg, m_last_reg;
    logic [ROW_W-1:0]      m_start_reg, m_end_reg;
    logic [CNT_W-1:0]      m_count_reg;

    // input unpack and clamp
    logic signed [IN_ROW_W-1:0] in_first, in_end;
    logic [ROW_W-1:0]           in_lo, in_hi;

    assign in_first = s_tdata[IN_ROW_W-1:0];
    assign in_end   = s_tdata[2*IN_ROW_W-1:IN_ROW_W];
    assign in_lo    = in_first[IN_ROW_W-1] ? '0 : in_first[ROW_W-1:0];
    assign in_hi    = (in_end[ROW_W-1:0] > screen_rows_reg) ? screen_rows_reg
                                                            : in_end[ROW_W-1:0];

    // single slot read port
    logic [CNT_W-1:0] last_cnt;
    logic [IDX_W-1:0] rd_addr;
    logic [ROW_W-1:0] rd_start, rd_end;
    logic signed [ROW_W:0] gap;

    assign last_cnt = count_reg - CNT_W'(1);

    always_comb begin
        if (cmd.move_last) begin
            rd_addr = last_cnt[IDX_W-1:0];
        end else if (cmd.take_best) begin
            rd_addr = best_reg;
        end else begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        if (int'(rd_addr) < SPAN_SLOTS) begin
            rd_start = starts_reg[rd_addr];
            rd_end   = ends_reg[rd_addr];
        end else begin
            rd_start = '0;
            rd_end   = '0;
        end
    end

    assign gap = (rd_start > hi_reg) ? ($signed({1'b0, rd_start}) - $signed({1'b0, hi_reg}))
                                     : ($signed({1'b0, lo_reg}) - $signed({1'b0, rd_end}));

    // status
    always_comb begin
        sts            = '0;
        sts.in_op      = op_t'(s_tuser);
        sts.in_empty   = in_end[IN_ROW_W-1] || (in_hi <= in_lo);
        sts.count_zero = (count_reg == '0);
        sts.scan_end   = (idx_reg == count_reg);
        sts.full       = (count_reg == CNT_W'(SPAN_SLOTS));
        sts.hit        = (rd_end >= lo_reg) && (rd_start <= hi_reg);
        sts.gap_last   = (idx_reg == CNT_W'(SPAN_SLOTS - 1));
        sts.list_last  = ((idx_reg + CNT_W'(1)) == count_reg);
        sts.out_free   = !m_valid_reg || m_tready;
    end

    // working state next values
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        victim_next  = victim_reg;
        best_next    = best_reg;
        min_gap_next = min_gap_reg;

        if (cmd.load_item) begin
            lo_next = in_lo;
            hi_next = in_hi;
        end
        if (cmd.absorb || cmd.take_best) begin
            lo_next     = (rd_start < lo_reg) ? rd_start : lo_reg;
            hi_next     = (rd_end > hi_reg) ? rd_end : hi_reg;
            victim_next = rd_addr;
        end
        if (cmd.gap_start) begin
            best_next    = '0;
            min_gap_next = $signed({1'b0, screen_rows_reg});
        end
        if (cmd.gap_step && (gap < min_gap_reg)) begin
            best_next    = rd_addr;
            min_gap_next = gap;
        end

        if (cmd.idx_clear || cmd.gap_start) begin
            idx_next = '0;
        end else if (cmd.idx_inc || cmd.gap_step) begin
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.clear_set) begin
            count_next = '0;
        end else if (cmd.move_last) begin
            count_next = last_cnt;
        end else if (cmd.store_new) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // slot write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_start, wr_end;

    always_comb begin
        wr_en    = cmd.move_last || cmd.store_new;
        wr_addr  = cmd.move_last ? victim_reg : count_reg[IDX_W-1:0];
        wr_start = cmd.move_last ? rd_start : lo_reg;
        wr_end   = cmd.move_last ? rd_end : hi_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            starts_reg[wr_addr] <= wr_start;
            ends_reg[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_rows_reg <= SCREEN_ROWS_RESET;
            count_reg       <= '0;
            idx_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                screen_rows_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.emit_flag || cmd.emit_span) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        victim_reg  <= victim_next;
        best_reg    <= best_next;
        min_gap_reg <= min_gap_next;
        if (cmd.emit_flag || cmd.emit_span) begin
            m_span_reg  <= cmd.emit_span;
            m_start_reg <= cmd.emit_span ? rd_start : '0;
            m_end_reg   <= cmd.emit_span ? rd_end : '0;
            m_count_reg <= count_reg;
            m_last_reg  <= cmd.emit_flag || sts.list_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_count_reg, m_end_reg, m_start_reg};
    assign m_tuser  = m_span_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- src/drsm_checker.sv -----
// Port-level checks for the span merger, bound to the top level.
// Depends on drsm_pkg and dirty_row_span_merger_unit_defines.svh.
`include "dirty_row_span_merger_unit_defines.svh"

module drsm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic [drsm_pkg::ROW_W-1:0]     cfg_wdata,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [drsm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [drsm_pkg::OP_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [drsm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import drsm_pkg::*;

    logic [ROW_W-1:0] chk_start, chk_end;
    logic [CNT_W-1:0] chk_count;

    assign chk_start = m_tdata[ROW_W-1:0];
    assign chk_end   = m_tdata[2*ROW_W-1:ROW_W];
    assign chk_count = m_tdata[2*ROW_W+CNT_W-1:2*ROW_W];

    // stalled result holds
    `DRSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")

    // a request is never followed by another in the next cycle
    `DRSM_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready,
        "request taken on back-to-back cycles")

    // result without a span is a lone, zeroed, final result
    `DRSM_ASSERT_NOW(a_flag_result, m_tvalid && !m_tuser,
        m_tlast && chk_start == '0 && chk_end == '0,
        "empty result carries span data")

    // a listed span is non-empty and within the slot count
    `DRSM_ASSERT_NOW(a_span_result, m_tvalid && m_tuser,
        chk_start < chk_end && chk_count != '0 && chk_count <= CNT_W'(SPAN_SLOTS),
        "listed span malformed")

endmodule

bind dirty_row_span_merger_unit drsm_checker u_drsm_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for dirty_row_span_merger_unit. A directed table runs first,
// then random requests; every result is checked against a span-set predictor or a typed-in value.
// Depends on drsm_pkg and the unit RTL.
module tb_top;
    import drsm_pkg::*;

    localparam int IDLE_PCT     = 36;         // chance per cycle that a side idles
    localparam int SETTLE       = 100;        // quiet cycles before a screen_rows write
    localparam int HOLD_OFF     = 400;        // receiver back-pressure stretch, in cycles
    localparam int PHASE_REQS   = 44;
    localparam int RUN_LIMIT_NS = 4_000_000;  // far beyond the slowest good run

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [ROW_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    dirty_row_span_merger_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // One result beat as the predictor expects it.
    typedef struct {
        bit             valid;
        bit [ROW_W-1:0] row_lo;
        bit [ROW_W-1:0] row_hi;
        bit [CNT_W-1:0] count;
        bit             last;
    } span_beat_t;

    span_beat_t spans_due[$];      // expected results, oldest first
    int         mismatches = 0;

    // Shadow copy of the span set and of screen_rows.
    bit [ROW_W-1:0] held_lo [SPAN_SLOTS];
    bit [ROW_W-1:0] held_hi [SPAN_SLOTS];
    bit [CNT_W-1:0] held_cnt      = '0;
    bit [ROW_W-1:0] screen_rows_q = SCREEN_ROWS_RESET;

    // Traffic shaping, shared by the sender and the receiver.
    bit steady_flow = 1'b0;        // no idling on either side
    int hold_cycles = 0;           // receiver picks this up and holds m_tready low

    // ------------------------------------------------------------------
    // Span-set predictor
    // ------------------------------------------------------------------

    // Freed slot is refilled from the last occupied one.
    function automatic void drop_slot(int idx);
        held_cnt--;
        held_lo[idx] = held_lo[held_cnt];
        held_hi[idx] = held_hi[held_cnt];
    endfunction

    function automatic void merge_span(int lo, int hi);
        int lim, idx, best, min_gap, gap, s, e;
        lim = screen_rows_q;
        if (lo < 0) lo = 0;
        if (hi > lim) hi = lim;
        if (hi <= lo) return;       // clamped to nothing: dropped
        while (1) begin
            // absorb anything overlapping or touching, restarting the scan each time
            idx = 0;
            while (idx < held_cnt) begin
                s = held_lo[idx];
                e = held_hi[idx];
                if (e >= lo && s <= hi) begin
                    if (s < lo) lo = s;
                    if (e > hi) hi = e;
                    drop_slot(idx);
                    idx = 0;
                end else begin
                    idx++;
                end
            end
            if (held_cnt < SPAN_SLOTS) break;
            // set full: fold in the nearest span; ties and "nothing closer than
            // screen_rows" both land on the lowest slot
            best    = 0;
            min_gap = lim;
            for (int k = 0; k < SPAN_SLOTS; k++) begin
                s   = held_lo[k];
                e   = held_hi[k];
                gap = (s > hi) ? s - hi : lo - e;
                if (gap < min_gap) begin
                    min_gap = gap;
                    best    = k;
                end
            end
            s = held_lo[best];
            e = held_hi[best];
            if (s < lo) lo = s;
            if (e > hi) hi = e;
            drop_slot(best);
        end
        held_lo[held_cnt] = ROW_W'(lo);
        held_hi[held_cnt] = ROW_W'(hi);
        held_cnt++;
    endfunction

    // Applies one request to the shadow set; queues its results when record is set.
    function automatic void predict_request(op_t op, bit [IN_ROW_W-1:0] first,
                                            bit [IN_ROW_W-1:0] stop, bit record);
        int lo, hi;
        lo = $signed(first);
        hi = $signed(stop);
        case (op)
            OP_ADD:   merge_span(lo, hi);
            OP_CLEAR: held_cnt = '0;
            default: ;
        endcase
        if (!record) return;
        if (op == OP_LIST && held_cnt != 0) begin
            for (int k = 0; k < held_cnt; k++)
                spans_due.push_back('{1'b1, held_lo[k], held_hi[k], held_cnt,
                                      k + 1 == held_cnt});
        end else begin
            spans_due.push_back('{1'b0, '0, '0, held_cnt, 1'b1});
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request, holding it until accepted. Valid stays high on return so
    // back-to-back requests keep it asserted; idles are inserted at the start.
    // A fixed_cnt of zero or more types in the single empty result directly.
    task automatic send_request(op_t op, bit [IN_ROW_W-1:0] first,
                                bit [IN_ROW_W-1:0] stop, int fixed_cnt);
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - 2 * IN_ROW_W){1'b0}}, stop, first};
        do @(posedge aclk); while (!s_tready);
        predict_request(op, first, stop, fixed_cnt < 0);
        if (fixed_cnt >= 0)
            spans_due.push_back('{1'b0, '0, '0, CNT_W'(fixed_cnt), 1'b1});
    endtask

    // Drain all outstanding results, then give the unit time to go idle.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (spans_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_screen_rows(int rows);
        cfg_we    <= 1'b1;
        cfg_wdata <= ROW_W'(rows);
        @(posedge aclk);
        cfg_we        <= 1'b0;
        screen_rows_q  = ROW_W'(rows);
    endtask

    // Mostly short ranges near the visible rows so spans touch, merge and fill the
    // set; some raw 13-bit operands for the full field range; lists often enough
    // to read the set back.
    task automatic random_request();
        int pick, lo, hi, lim;
        lim  = screen_rows_q;
        pick = $urandom_range(99);
        if (pick < 64) begin
            lo = int'($urandom_range(lim)) - int'($urandom_range(8));
            hi = lo + int'($urandom_range(lim / 8 + 2));
            if (hi > 4095) hi = 4095;
            send_request(OP_ADD, IN_ROW_W'(lo), IN_ROW_W'(hi), -1);
        end else if (pick < 72) begin
            send_request(OP_ADD, IN_ROW_W'($urandom), IN_ROW_W'($urandom), -1);
        end else if (pick < 88) begin
            send_request(OP_LIST, IN_ROW_W'($urandom), IN_ROW_W'($urandom), -1);
        end else if (pick < 93) begin
            send_request(OP_CLEAR, IN_ROW_W'($urandom), IN_ROW_W'($urandom), -1);
        end else begin
            send_request(OP_NOP, IN_ROW_W'($urandom), IN_ROW_W'($urandom), -1);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        op_t       op;
        int        first;      // on a config row: the screen_rows value
        int        stop;
        int        fixed_cnt;  // typed-in span_count of the one empty result; -1: predictor
    } plan_row_t;

    localparam int PLAN_LEN = 27;

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_REQ, OP_LIST,     0,    0,  0},  // list of the empty set after reset
        '{ROW_REQ, OP_ADD,  -4096, 4095,  1},  // extreme operands clamp to 0..480
        '{ROW_REQ, OP_LIST,     0,    0, -1},
        '{ROW_REQ, OP_CLEAR,    0,    0,  0},
        '{ROW_REQ, OP_ADD,     20,   10,  0},  // reversed range: dropped
        '{ROW_REQ, OP_ADD,    500,  600,  0},  // wholly past screen_rows: dropped
        '{ROW_REQ, OP_NOP,      0,    0,  0},
        '{ROW_REQ, OP_ADD,      5,   10,  1},
        '{ROW_REQ, OP_ADD,     10,   20,  1},  // touching span merges
        '{ROW_REQ, OP_ADD,     40,   50,  2},
        '{ROW_REQ, OP_ADD,     15,   45,  1},  // bridges both, scan restarts
        '{ROW_CFG, OP_NOP,   4095,    0, -1},
        '{ROW_REQ, OP_ADD,   3000, 3010, -1},
        '{ROW_REQ, OP_ADD,   3100, 3110, -1},
        '{ROW_REQ, OP_ADD,   3200, 3210, -1},
        '{ROW_REQ, OP_ADD,   3300, 3310, -1},
        '{ROW_REQ, OP_ADD,   3400, 3410, -1},  // set now full
        '{ROW_REQ, OP_ADD,   4090, 4095, -1},  // forced merge with nearest span
        '{ROW_REQ, OP_LIST,     0,    0, -1},
        '{ROW_CFG, OP_NOP,      1,    0, -1},  // lowered below every stored span
        '{ROW_REQ, OP_ADD,     -3,    9, -1},  // no gap below 1: falls back to slot 0
        '{ROW_REQ, OP_LIST,     0,    0, -1},
        '{ROW_CFG, OP_NOP,      0,    0, -1},  // zero rows: every add drops
        '{ROW_REQ, OP_ADD,      0, 4095, -1},
        '{ROW_REQ, OP_LIST,     0,    0, -1},
        '{ROW_CFG, OP_NOP,    480,    0, -1},
        '{ROW_REQ, OP_CLEAR,    0,    0,  0}
    };

    // screen_rows per random phase; -1 draws a random legal value
    int phase_rows [10] = '{4095, 64, 1, 480, 2, 0, 32, 4095, -1, 12};

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int rows;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ADD;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                settle_idle();
                write_screen_rows(plan[k].first);
            end else begin
                send_request(plan[k].op, IN_ROW_W'(plan[k].first),
                             IN_ROW_W'(plan[k].stop), plan[k].fixed_cnt);
            end
        end

        foreach (phase_rows[p]) begin
            settle_idle();
            rows = (phase_rows[p] < 0) ? int'($urandom_range(4095, 1)) : phase_rows[p];
            write_screen_rows(rows);
            // one phase with the receiver stalled long enough to back up the input,
            // another with both sides streaming flat out
            if (p == 3) hold_cycles = HOLD_OFF;
            steady_flow = (p == 7);
            repeat ((rows == 0) ? 10 : PHASE_REQS) random_request();
        end
        steady_flow = 1'b0;

        settle_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else begin
                m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // m_tdata: span_start, span_end, span_count from bit 0 up
    always @(posedge aclk) begin : result_check
        span_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (spans_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = spans_due.pop_front();
                check_field("span_valid", want.valid, m_tuser);
                check_field("span_start", want.row_lo, m_tdata[ROW_W-1:0]);
                check_field("span_end", want.row_hi, m_tdata[2*ROW_W-1:ROW_W]);
                check_field("span_count", want.count, m_tdata[2*ROW_W+CNT_W-1:2*ROW_W]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+src
src/drsm_pkg.sv
src/drsm_ctrl.sv
src/drsm_dp.sv
src/dirty_row_span_merger_unit.sv
src/drsm_checker.sv
dv/tb_top.sv
